@@ hw/rtl/ssh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssh_pkg: shared types and constants of the solar surplus heater controller
// Command and mode codes, register indexes, reset values and the structs that
// pass between the ring averager, the control unit and the top level.
// ----------------------------------------------------------------------------
package ssh_pkg;

    // Item commands
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_TICK   = 2'd1;
    localparam logic [1:0] CMD_BUTTON = 2'd2;

    // Mode codes reported with each result
    localparam logic [2:0] MODE_HEAT    = 3'd0;
    localparam logic [2:0] MODE_TARIFF  = 3'd1;
    localparam logic [2:0] MODE_SUNNY   = 3'd2;
    localparam logic [2:0] MODE_FORCED  = 3'd3;
    localparam logic [2:0] MODE_TEMP_OK = 3'd4;
    localparam logic [2:0] MODE_MANUAL  = 3'd5;
    localparam logic [2:0] MODE_IDLE    = 3'd6;
    localparam logic [2:0] MODE_FULL    = 3'd7;

    // Configuration register indexes
    localparam logic [2:0] REG_FORCE_TEMP    = 3'd0;
    localparam logic [2:0] REG_RELEASE_TEMP  = 3'd1;
    localparam logic [2:0] REG_SUNNY_LIMIT   = 3'd2;
    localparam logic [2:0] REG_FORCED_LEVEL  = 3'd3;
    localparam logic [2:0] REG_FORBID        = 3'd4;
    localparam logic [2:0] REG_FORCE_DELAY   = 3'd5;
    localparam logic [2:0] REG_FORCE_LENGTH  = 3'd6;
    localparam logic [2:0] REG_MANUAL_LENGTH = 3'd7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    // Register reset values
    localparam logic signed [18:0] FORCE_TEMP_RST    = 19'sd4000;
    localparam logic signed [18:0] RELEASE_TEMP_RST  = 19'sd4500;
    localparam logic [15:0]        SUNNY_LIMIT_RST   = 16'd750;
    localparam logic [7:0]         FORCED_LEVEL_RST  = 8'd190;
    localparam logic [17:0]        FORCE_DELAY_RST   = 18'd252000;
    localparam logic [16:0]        FORCE_LENGTH_RST  = 17'd108000;
    localparam logic [15:0]        MANUAL_LENGTH_RST = 16'd36000;

    // Level ramp constants
    localparam logic [7:0] LVL_STEP_DOWN = 8'd25;
    localparam logic [7:0] LVL_STEP_UP   = 8'd10;
    localparam logic [7:0] LVL_UP_LIMIT  = 8'd245;
    localparam logic [7:0] LVL_MAX       = 8'd255;

    // Manual activation ends once the countdown is below this
    localparam logic [15:0] MANUAL_END = 16'd10;

    typedef struct packed {
        logic signed [18:0] force_temp;
        logic signed [18:0] release_temp;
        logic [15:0]        sunny_limit;
        logic [7:0]         forced_level;
        logic               forbid;
        logic [17:0]        force_delay;
        logic [16:0]        force_length;
        logic [15:0]        manual_length;
    } ssh_cfg_t;

    typedef struct packed {
        logic        point;     // this sample lands on an averaging point
        logic [15:0] solar;
        logic [15:0] home;
    } ssh_avg_t;

    typedef struct packed {
        logic [7:0]  drive_level;
        logic [2:0]  mode_code;
        logic [15:0] avg_solar;
        logic [15:0] avg_home;
        logic        forcing;
    } ssh_result_t;

endpackage

@@ hw/rtl/solar_surplus_heater_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// solar_surplus_heater_controller: heater drive level from solar surplus
// Usage:
//  s_* channel takes one item per cycle while m_* is not stalled: a sample
//  (readings, temperature, tariff input), a timer tick or a button release,
//  selected by s_command. m_* channel gives one result for each sample that
//  completes half a ring: drive level, mode code, the two averages and the
//  forcing flag. Ticks, buttons and other samples give no result.
//  An accepted item waits in the input register until the result register
//  is free or being emptied; it is then processed and its result is
//  registered onto m_*.
//  Throughput: one item per cycle unless m_* stalls; the input and result
//  registers each hold one item, and the single-pass decision logic between
//  them (ring update, reciprocal multiply, rules) sets the cycle time.
//  When m_ready is low with a result waiting, an empty input register still
//  takes one item, then s_ready stays low until the result is taken.
//  Reset: rings and sums read as zero, level and forcing cleared, timers at
//  their default counts, registers at defaults. No clearing pass is needed.
//  cfg_wr_en writes cfg_wdata to register cfg_index; write only while no
//  item is in flight.
// ----------------------------------------------------------------------------
module solar_surplus_heater_controller import ssh_pkg::*; #(
    parameter int RING_DEPTH = 20
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_command,
    input  logic [9:0]            s_solar_raw,
    input  logic [9:0]            s_home_raw,
    input  logic signed [18:0]    s_temp_centi,
    input  logic                  s_tariff_pin,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_drive_level,
    output logic [2:0]            m_mode_code,
    output logic [15:0]           m_avg_solar,
    output logic [15:0]           m_avg_home,
    output logic                  m_forcing,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    ssh_cfg_t           cfg_reg;
    logic               in_valid_reg;
    logic [1:0]         cmd_reg;
    logic [9:0]         solar_reg;
    logic [9:0]         home_reg;
    logic signed [18:0] temp_reg;
    logic               tariff_reg;
    logic               out_valid_reg, out_valid_next;
    ssh_result_t        out_reg;
    logic               step;
    logic               res_valid;
    ssh_result_t        res;
    ssh_avg_t           avg;

    // Process the held item when the result slot is free or being emptied
    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.force_temp    <= FORCE_TEMP_RST;
            cfg_reg.release_temp  <= RELEASE_TEMP_RST;
            cfg_reg.sunny_limit   <= SUNNY_LIMIT_RST;
            cfg_reg.forced_level  <= FORCED_LEVEL_RST;
            cfg_reg.forbid        <= 1'b0;
            cfg_reg.force_delay   <= FORCE_DELAY_RST;
            cfg_reg.force_length  <= FORCE_LENGTH_RST;
            cfg_reg.manual_length <= MANUAL_LENGTH_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FORCE_TEMP:    cfg_reg.force_temp    <= $signed(cfg_wdata);
                REG_RELEASE_TEMP:  cfg_reg.release_temp  <= $signed(cfg_wdata);
                REG_SUNNY_LIMIT:   cfg_reg.sunny_limit   <= cfg_wdata[15:0];
                REG_FORCED_LEVEL:  cfg_reg.forced_level  <= cfg_wdata[7:0];
                REG_FORBID:        cfg_reg.forbid        <= cfg_wdata[0];
                REG_FORCE_DELAY:   cfg_reg.force_delay   <= cfg_wdata[17:0];
                REG_FORCE_LENGTH:  cfg_reg.force_length  <= cfg_wdata[16:0];
                REG_MANUAL_LENGTH: cfg_reg.manual_length <= cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // Input register: hold the item until it is processed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg    <= s_command;
            solar_reg  <= s_solar_raw;
            home_reg   <= s_home_raw;
            temp_reg   <= s_temp_centi;
            tariff_reg <= s_tariff_pin;
        end
    end

    ssh_ring_avg #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring_avg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (step && cmd_reg == CMD_SAMPLE),
        .solar_raw (solar_reg),
        .home_raw  (home_reg),
        .avg       (avg)
    );

    ssh_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .command    (cmd_reg),
        .temp_centi (temp_reg),
        .tariff_pin (tariff_reg),
        .cfg        (cfg_reg),
        .avg        (avg),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Result register
    assign out_valid_next = step ? res_valid : (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_drive_level = out_reg.drive_level;
    assign m_mode_code   = out_reg.mode_code;
    assign m_avg_solar   = out_reg.avg_solar;
    assign m_avg_home    = out_reg.avg_home;
    assign m_forcing     = out_reg.forcing;

`ifndef SYNTHESIS
    // Forced heating never ramps, so it never reports idle or full
    a_forced_no_ramp: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.forcing |->
            out_reg.mode_code != MODE_IDLE && out_reg.mode_code != MODE_FULL)
        else $error("forced result reports a ramp mode");

    // Manual activation always leaves forcing set
    a_manual_forces: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.mode_code == MODE_MANUAL |-> out_reg.forcing)
        else $error("manual mode without forcing");

    // Cancel modes always leave forcing clear
    a_cancel_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_reg.mode_code == MODE_TARIFF ||
            out_reg.mode_code == MODE_SUNNY || out_reg.mode_code == MODE_TEMP_OK)
            |-> !out_reg.forcing)
        else $error("cancel mode with forcing set");

    // A waiting result blocks processing of the held item
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |-> !step)
        else $error("item processed while result stalled");
`endif

endmodule

@@ hw/rtl/ssh_ring_avg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssh_ring_avg: solar and home reading rings with running sums
// Stores scaled readings in two rings, keeps their sums and gives the averages
// of the sums after the current sample, with a flag on averaging points.
// ----------------------------------------------------------------------------
module ssh_ring_avg import ssh_pkg::*; #(
    parameter int RING_DEPTH = 20
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       wr_en,
    input  logic [9:0] solar_raw,
    input  logic [9:0] home_raw,
    output ssh_avg_t   avg
);

    localparam int IDX_W  = $clog2(RING_DEPTH);
    localparam int SUM_W  = 16 + IDX_W;
    localparam int SHIFT  = SUM_W + IDX_W;
    localparam int PROD_W = 2 * SUM_W + 1;
    localparam longint unsigned RECIP_L =
        ((longint'(1) << SHIFT) + longint'(RING_DEPTH) - 1) / longint'(RING_DEPTH);
    localparam logic [SUM_W:0] RECIP = RECIP_L[SUM_W:0];
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);
    localparam logic [IDX_W-1:0] IDX_HALF = IDX_W'(RING_DEPTH / 2);
    localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

    logic [15:0] solar_mem [RING_DEPTH];
    logic [15:0] home_mem  [RING_DEPTH];

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             filled_reg;
    logic [SUM_W-1:0] solar_sum_reg, solar_sum_next;
    logic [SUM_W-1:0] home_sum_reg, home_sum_next;
    logic [15:0]      solar_rd_reg, home_rd_reg;
    logic [15:0]      solar_scaled, home_scaled;
    logic [15:0]      solar_old, home_old;
    logic [PROD_W-1:0] solar_prod, home_prod;

    assign solar_scaled = {solar_raw, 6'b0};
    assign home_scaled  = {home_raw, 6'b0};

    // Advance the write index, wrapping at the ring end
    always_comb begin
        idx_next = idx_reg;
        if (wr_en) begin
            idx_next = (idx_reg == IDX_LAST) ? '0 : idx_reg + IDX_ONE;
        end
    end

    // Entries not yet written since reset read as zero
    assign solar_old = filled_reg ? solar_rd_reg : 16'd0;
    assign home_old  = filled_reg ? home_rd_reg : 16'd0;

    assign solar_sum_next = solar_sum_reg - SUM_W'(solar_old) + SUM_W'(solar_scaled);
    assign home_sum_next  = home_sum_reg - SUM_W'(home_old) + SUM_W'(home_scaled);

    // Divide by the ring depth as a multiply by its reciprocal
    assign solar_prod = PROD_W'(solar_sum_next) * PROD_W'(RECIP);
    assign home_prod  = PROD_W'(home_sum_next) * PROD_W'(RECIP);

    assign avg.point = wr_en && (idx_next == '0 || idx_next == IDX_HALF);
    assign avg.solar = solar_prod[SHIFT +: 16];
    assign avg.home  = home_prod[SHIFT +: 16];

    // Control state: index, fill flag and sums
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            filled_reg    <= 1'b0;
            solar_sum_reg <= '0;
            home_sum_reg  <= '0;
        end else if (wr_en) begin
            idx_reg       <= idx_next;
            solar_sum_reg <= solar_sum_next;
            home_sum_reg  <= home_sum_next;
            if (idx_reg == IDX_LAST) begin
                filled_reg <= 1'b1;
            end
        end
    end

    // Write the new reading; prefetch the entry that the next sample replaces
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            solar_mem[idx_reg] <= solar_scaled;
            home_mem[idx_reg]  <= home_scaled;
        end
        solar_rd_reg <= solar_mem[idx_next];
        home_rd_reg  <= home_mem[idx_next];
    end

endmodule

@@ hw/rtl/ssh_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssh_ctrl: heater level decision and timers
// Runs the forcing, sunny, tariff, forbid and manual rules on averaging
// samples and ramps the level; ticks count timers down, a button arms manual.
// ----------------------------------------------------------------------------
module ssh_ctrl import ssh_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  logic [1:0]         command,
    input  logic signed [18:0] temp_centi,
    input  logic               tariff_pin,
    input  ssh_cfg_t           cfg,
    input  ssh_avg_t           avg,
    output logic               res_valid,
    output ssh_result_t        res
);

    logic [7:0]  level_reg, level_next;
    logic        forced_reg, forced_next;
    logic [17:0] delay_reg, delay_next;
    logic [16:0] length_reg, length_next;
    logic [15:0] manual_reg, manual_next;
    logic [2:0]  mode;

    always_comb begin
        level_next  = level_reg;
        forced_next = forced_reg;
        delay_next  = delay_reg;
        length_next = length_reg;
        manual_next = manual_reg;
        mode        = MODE_HEAT;
        res_valid   = 1'b0;
        case (command)
            CMD_TICK: begin
                if (manual_reg != 16'd0) begin
                    manual_next = manual_reg - 16'd1;
                end
                if (forced_reg) begin
                    if (delay_reg != 18'd0) begin
                        delay_next = delay_reg - 18'd1;
                    end
                    if (length_reg != 17'd0) begin
                        length_next = length_reg - 17'd1;
                    end
                end
            end
            CMD_BUTTON: begin
                manual_next = cfg.manual_length;
            end
            CMD_SAMPLE: begin
                if (avg.point) begin
                    res_valid = 1'b1;
                    // Forced heating by temperature
                    if (temp_centi < cfg.force_temp) begin
                        forced_next = 1'b1;
                        mode        = MODE_FORCED;
                    end else if (temp_centi > cfg.release_temp && forced_reg) begin
                        forced_next = 1'b0;
                        level_next  = 8'd0;
                        mode        = MODE_TEMP_OK;
                    end
                    // Sunny day cancels forcing
                    if (avg.solar > cfg.sunny_limit) begin
                        forced_next = 1'b0;
                        mode        = MODE_SUNNY;
                        delay_next  = cfg.force_delay;
                    end
                    // Peak tariff day blocks forcing
                    if (!tariff_pin) begin
                        forced_next = 1'b0;
                        mode        = MODE_TARIFF;
                    end
                    if (cfg.forbid) begin
                        forced_next = 1'b0;
                    end
                    // Manual activation overrides all
                    if (manual_reg > 16'd1) begin
                        forced_next = 1'b1;
                        mode        = MODE_MANUAL;
                        if (manual_reg < MANUAL_END) begin
                            manual_next = 16'd0;
                        end
                    end
                    // Apply forced level or ramp
                    if (forced_next) begin
                        if (delay_next == 18'd0 && length_reg != 17'd0) begin
                            level_next = cfg.forced_level;
                        end
                        if (length_reg == 17'd0) begin
                            delay_next  = cfg.force_delay;
                            length_next = cfg.force_length;
                        end
                    end else if (avg.solar < avg.home) begin
                        if (level_next > LVL_STEP_DOWN) begin
                            level_next = level_next - LVL_STEP_DOWN;
                        end else begin
                            level_next = 8'd0;
                            mode       = MODE_IDLE;
                        end
                    end else begin
                        if (level_next < LVL_UP_LIMIT) begin
                            level_next = level_next + LVL_STEP_UP;
                        end else begin
                            level_next = LVL_MAX;
                            mode       = MODE_FULL;
                        end
                    end
                end
            end
            default: begin
                // Unknown command: drop it
            end
        endcase
    end

    assign res.drive_level = level_next;
    assign res.mode_code   = mode;
    assign res.avg_solar   = avg.solar;
    assign res.avg_home    = avg.home;
    assign res.forcing     = forced_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg  <= 8'd0;
            forced_reg <= 1'b0;
            delay_reg  <= FORCE_DELAY_RST;
            length_reg <= FORCE_LENGTH_RST;
            manual_reg <= 16'd0;
        end else if (step) begin
            level_reg  <= level_next;
            forced_reg <= forced_next;
            delay_reg  <= delay_next;
            length_reg <= length_next;
            manual_reg <= manual_next;
        end
    end

endmodule

@@ sim/tb_solar_surplus_heater_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_solar_surplus_heater_controller: self-checking bench for the heater
// controller
// A short table of hand-picked items runs first at the reset settings. Then
// several register settings follow, each with a random mix of samples, timer
// ticks, button presses and unused commands. Averaging samples are predicted
// by a behavioral model in the bench, two table rows by hand. Each result is
// compared field by field while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_solar_surplus_heater_controller import ssh_pkg::*;;

    localparam int         RING_DEPTH     = 20;
    localparam int         PHASE_ITEMS    = 140;
    localparam int         LAST_PHASE     = 6;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam logic [1:0] CMD_UNUSED     = 2'd3;

    // One input item, plus an optional hand-written result for table rows
    typedef struct packed {
        logic [1:0]         cmd;
        logic [9:0]         solar;
        logic [9:0]         home;
        logic signed [18:0] temp;
        logic               tariff;
        logic               typed;
        ssh_result_t        want;
    } heater_row_t;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_command = '0;
    logic [9:0]            s_solar_raw = '0;
    logic [9:0]            s_home_raw = '0;
    logic signed [18:0]    s_temp_centi = '0;
    logic                  s_tariff_pin = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [7:0]            m_drive_level;
    logic [2:0]            m_mode_code;
    logic [15:0]           m_avg_solar;
    logic [15:0]           m_avg_home;
    logic                  m_forcing;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Behavioral copy of the controller state and registers
    ssh_cfg_t    heater_cfg;
    logic [15:0] solar_hist [RING_DEPTH];
    logic [15:0] home_hist [RING_DEPTH];
    logic [20:0] solar_total;
    logic [20:0] home_total;
    int          ring_pos;
    logic [7:0]  lvl;
    logic        forced_on;
    logic [17:0] delay_cnt;
    logic [16:0] length_cnt;
    logic [15:0] manual_cnt;

    ssh_result_t decision_q [$];

    int errors = 0;
    int results_checked = 0;
    int decisions_predicted = 0;
    int sample_count = 0;
    int tick_count = 0;
    int press_count = 0;
    int unused_count = 0;
    int source_burst = 0;
    int stall_cycles = 0;
    int mode_seen [8];

    solar_surplus_heater_controller #(
        .RING_DEPTH(RING_DEPTH)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_solar_raw   (s_solar_raw),
        .s_home_raw    (s_home_raw),
        .s_temp_centi  (s_temp_centi),
        .s_tariff_pin  (s_tariff_pin),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_drive_level (m_drive_level),
        .m_mode_code   (m_mode_code),
        .m_avg_solar   (m_avg_solar),
        .m_avg_home    (m_avg_home),
        .m_forcing     (m_forcing),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Apply one register write to the model
    function automatic void heater_config_write(input logic [2:0] idx, input int value);
        case (idx)
            REG_FORCE_TEMP:    heater_cfg.force_temp = value[18:0];
            REG_RELEASE_TEMP:  heater_cfg.release_temp = value[18:0];
            REG_SUNNY_LIMIT:   heater_cfg.sunny_limit = value[15:0];
            REG_FORCED_LEVEL:  heater_cfg.forced_level = value[7:0];
            REG_FORBID:        heater_cfg.forbid = value[0];
            REG_FORCE_DELAY:   heater_cfg.force_delay = value[17:0];
            REG_FORCE_LENGTH:  heater_cfg.force_length = value[16:0];
            REG_MANUAL_LENGTH: heater_cfg.manual_length = value[15:0];
            default: ;
        endcase
    endfunction

    // Advance the model by one item; return 1 when a result is due
    function automatic bit heater_predict(input heater_row_t it, output ssh_result_t res);
        logic [15:0] solar_scaled;
        logic [15:0] home_scaled;
        logic [15:0] avg_s;
        logic [15:0] avg_h;
        logic [2:0]  mode;
        res = '0;
        if (it.cmd == CMD_TICK) begin
            if (manual_cnt != 0) manual_cnt = manual_cnt - 1'b1;
            if (forced_on) begin
                if (delay_cnt != 0) delay_cnt = delay_cnt - 1'b1;
                if (length_cnt != 0) length_cnt = length_cnt - 1'b1;
            end
            return 1'b0;
        end
        if (it.cmd == CMD_BUTTON) begin
            manual_cnt = heater_cfg.manual_length;
            return 1'b0;
        end
        if (it.cmd != CMD_SAMPLE) return 1'b0;

        // Replace the oldest ring entry and keep the running sums
        solar_scaled = {it.solar, 6'd0};
        home_scaled = {it.home, 6'd0};
        solar_total = solar_total - solar_hist[ring_pos] + solar_scaled;
        home_total = home_total - home_hist[ring_pos] + home_scaled;
        solar_hist[ring_pos] = solar_scaled;
        home_hist[ring_pos] = home_scaled;
        ring_pos++;
        if (ring_pos == RING_DEPTH) ring_pos = 0;
        if (ring_pos != 0 && ring_pos != RING_DEPTH / 2) return 1'b0;

        avg_s = 16'(solar_total / RING_DEPTH);
        avg_h = 16'(home_total / RING_DEPTH);
        mode = MODE_HEAT;

        // Rules in priority order: the later ones override
        if ($signed(it.temp) < $signed(heater_cfg.force_temp)) begin
            forced_on = 1'b1;
            mode = MODE_FORCED;
        end else if ($signed(it.temp) > $signed(heater_cfg.release_temp) && forced_on) begin
            forced_on = 1'b0;
            lvl = '0;
            mode = MODE_TEMP_OK;
        end
        if (avg_s > heater_cfg.sunny_limit) begin
            forced_on = 1'b0;
            mode = MODE_SUNNY;
            delay_cnt = heater_cfg.force_delay;
        end
        if (!it.tariff) begin
            forced_on = 1'b0;
            mode = MODE_TARIFF;
        end
        if (heater_cfg.forbid) forced_on = 1'b0;
        if (manual_cnt > 1) begin
            forced_on = 1'b1;
            mode = MODE_MANUAL;
            if (manual_cnt < MANUAL_END) manual_cnt = '0;
        end

        // Forced level after the delay, otherwise ramp on the surplus
        if (forced_on) begin
            if (delay_cnt == 0 && length_cnt != 0) lvl = heater_cfg.forced_level;
            if (length_cnt == 0) begin
                delay_cnt = heater_cfg.force_delay;
                length_cnt = heater_cfg.force_length;
            end
        end else if (avg_s < avg_h) begin
            if (lvl > LVL_STEP_DOWN) begin
                lvl = lvl - LVL_STEP_DOWN;
            end else begin
                lvl = '0;
                mode = MODE_IDLE;
            end
        end else begin
            if (lvl < LVL_UP_LIMIT) begin
                lvl = lvl + LVL_STEP_UP;
            end else begin
                lvl = LVL_MAX;
                mode = MODE_FULL;
            end
        end

        res.drive_level = lvl;
        res.mode_code = mode;
        res.avg_solar = avg_s;
        res.avg_home = avg_h;
        res.forcing = forced_on;
        return 1'b1;
    endfunction

    // Wait to insert before the next handshake, with idle-free bursts now and then
    function automatic int draw_wait(inout int burst_left);
        if (burst_left > 0) begin
            burst_left = burst_left - 1;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst_left = $urandom_range(15, 40);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    function automatic heater_row_t make_row(input logic [1:0] cmd, input logic [9:0] solar,
                                             input logic [9:0] home, input int temp,
                                             input logic tariff);
        heater_row_t it;
        it = '0;
        it.cmd = cmd;
        it.solar = solar;
        it.home = home;
        it.temp = 19'(temp);
        it.tariff = tariff;
        return it;
    endfunction

    // Mostly low readings; temperatures often around the thresholds
    function automatic heater_row_t random_item();
        heater_row_t it;
        int pick;
        int anchor;
        it = '0;
        pick = $urandom_range(0, 99);
        if (pick < 62) it.cmd = CMD_SAMPLE;
        else if (pick < 88) it.cmd = CMD_TICK;
        else if (pick < 94) it.cmd = CMD_BUTTON;
        else it.cmd = CMD_UNUSED;
        it.solar = ($urandom_range(0, 99) < 8) ? 10'($urandom) : 10'($urandom_range(0, 40));
        it.home = ($urandom_range(0, 99) < 30) ? 10'($urandom) : 10'($urandom_range(0, 40));
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            anchor = ($urandom_range(0, 1) == 0) ? int'($signed(heater_cfg.force_temp))
                                                 : int'($signed(heater_cfg.release_temp));
            it.temp = 19'(anchor + int'($urandom_range(0, 600)) - 300);
        end else if (pick < 75) begin
            it.temp = 19'(int'($urandom_range(0, 207000)) - 27000);
        end else begin
            it.temp = 19'($urandom);
        end
        it.tariff = ($urandom_range(0, 9) != 0);
        return it;
    endfunction

    // Present one item, hold it until accepted, then predict its result
    task automatic send_item(input heater_row_t it);
        int gap;
        ssh_result_t predicted;
        gap = draw_wait(source_burst);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= it.cmd;
        s_solar_raw <= it.solar;
        s_home_raw <= it.home;
        s_temp_centi <= it.temp;
        s_tariff_pin <= it.tariff;
        do @(posedge aclk); while (!(s_valid && s_ready));
        case (it.cmd)
            CMD_SAMPLE: sample_count++;
            CMD_TICK:   tick_count++;
            CMD_BUTTON: press_count++;
            default:    unused_count++;
        endcase
        if (heater_predict(it, predicted)) begin
            decisions_predicted++;
            decision_q.push_back(it.typed ? it.want : predicted);
        end
    endtask

    // Hold the sender until every predicted result has come out
    task automatic drain_decisions();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (decision_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_DATA_W-1:0];
        @(posedge aclk);
        heater_config_write(idx, value);
    endtask

    task automatic program_regs(input int force_t, input int rel_t, input int sunny,
                                input int flevel, input int forbid, input int delay,
                                input int length, input int manual);
        write_reg(REG_FORCE_TEMP, force_t);
        write_reg(REG_RELEASE_TEMP, rel_t);
        write_reg(REG_SUNNY_LIMIT, sunny);
        write_reg(REG_FORCED_LEVEL, flevel);
        write_reg(REG_FORBID, forbid);
        write_reg(REG_FORCE_DELAY, delay);
        write_reg(REG_FORCE_LENGTH, length);
        write_reg(REG_MANUAL_LENGTH, manual);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want_v, got_v);
            errors++;
        end
    endtask

    // Result sink: random stalls between results, ready held across bursts
    initial begin : result_sink
        int stall;
        int sink_burst;
        sink_burst = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = draw_wait(sink_burst);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // Compare each taken result with the oldest prediction
    always @(posedge aclk) begin : result_check
        ssh_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            mode_seen[m_mode_code]++;
            if (decision_q.size() == 0) begin
                $display("%0t: result with none expected: expected nothing, got level %0d mode %0d",
                         $time, m_drive_level, m_mode_code);
                errors++;
            end else begin
                want = decision_q.pop_front();
                check_field("drive_level", want.drive_level, m_drive_level);
                check_field("mode_code", want.mode_code, m_mode_code);
                check_field("avg_solar", want.avg_solar, m_avg_solar);
                check_field("avg_home", want.avg_home, m_avg_home);
                check_field("forcing", want.forcing, m_forcing);
            end
        end
    end

    // Stop a hung run: count cycles with no handshake and no register write
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, stall_cycles, decision_q.size());
            $display("tb_solar_surplus_heater_controller NOT OK");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        int i;
        int phase;
        int n;
        int force_t;
        int rel_t;
        heater_row_t row;
        heater_row_t directed_rows [$];

        // Model state after reset
        heater_cfg.force_temp = FORCE_TEMP_RST;
        heater_cfg.release_temp = RELEASE_TEMP_RST;
        heater_cfg.sunny_limit = SUNNY_LIMIT_RST;
        heater_cfg.forced_level = FORCED_LEVEL_RST;
        heater_cfg.forbid = 1'b0;
        heater_cfg.force_delay = FORCE_DELAY_RST;
        heater_cfg.force_length = FORCE_LENGTH_RST;
        heater_cfg.manual_length = MANUAL_LENGTH_RST;
        for (i = 0; i < RING_DEPTH; i++) begin
            solar_hist[i] = '0;
            home_hist[i] = '0;
        end
        solar_total = '0;
        home_total = '0;
        ring_pos = 0;
        lvl = '0;
        forced_on = 1'b0;
        delay_cnt = FORCE_DELAY_RST;
        length_cnt = FORCE_LENGTH_RST;
        manual_cnt = '0;
        for (i = 0; i < 8; i++) mode_seen[i] = 0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table at reset settings: unused command and a tick first
        directed_rows.push_back(make_row(CMD_UNUSED, 10'h3FF, 10'h3FF, -1, 1'b1));
        directed_rows.push_back(make_row(CMD_TICK, 10'h3FF, 10'h000, 0, 1'b0));
        // Half ring of zero readings: ramp up from zero, top temperature
        for (i = 0; i < 9; i++)
            directed_rows.push_back(make_row(CMD_SAMPLE, 10'd0, 10'd0, 5000, 1'b1));
        row = make_row(CMD_SAMPLE, 10'd0, 10'd0, 262143, 1'b1);
        row.typed = 1'b1;
        row.want = {8'd10, MODE_HEAT, 16'd0, 16'd0, 1'b0};
        directed_rows.push_back(row);
        // Full-scale readings, bottom temperature, peak tariff, then a button:
        // manual activation wins over every other rule
        for (i = 0; i < 9; i++)
            directed_rows.push_back(make_row(CMD_SAMPLE, 10'h3FF, 10'h3FF, -262144, 1'b0));
        directed_rows.push_back(make_row(CMD_BUTTON, 10'd0, 10'd0, 0, 1'b1));
        row = make_row(CMD_SAMPLE, 10'h3FF, 10'h3FF, -262144, 1'b0);
        row.typed = 1'b1;
        row.want = {8'd10, MODE_MANUAL, 16'd32736, 16'd32736, 1'b1};
        directed_rows.push_back(row);
        directed_rows.push_back(make_row(CMD_TICK, 10'd0, 10'd0, 0, 1'b1));
        foreach (directed_rows[i]) send_item(directed_rows[i]);

        // Random phases, each under its own register setting
        for (phase = 1; phase <= LAST_PHASE; phase++) begin
            drain_decisions();
            repeat (4) @(posedge aclk);
            case (phase)
                1: program_regs(2000, 2600, 750, 200, 0, 3, 5, 12);
                2: program_regs(180000, 180000, 65535, 255, 0, 0, 0, 0);
                3: program_regs(-27000, -27000, 0, 0, 1, 262143, 131071, 65535);
                default: begin
                    force_t = int'($urandom_range(0, 207000)) - 27000;
                    rel_t = force_t + int'($urandom_range(0, 1500));
                    if (rel_t > 180000) rel_t = 180000;
                    program_regs(force_t, rel_t, $urandom_range(0, 1500),
                                 $urandom_range(0, 255), ($urandom_range(0, 3) == 0),
                                 $urandom_range(0, 6), $urandom_range(0, 8),
                                 $urandom_range(0, 20));
                end
            endcase
            n = 0;
            while (n < PHASE_ITEMS || (phase == LAST_PHASE && decisions_predicted < 50)) begin
                if (n == PHASE_ITEMS / 2) drain_decisions();
                send_item(random_item());
                n++;
            end
        end

        drain_decisions();
        repeat (8) @(posedge aclk);

        $display("covered %0d items: %0d samples, %0d ticks, %0d presses, %0d unused codes; %0d results checked over %0d settings",
                 sample_count + tick_count + press_count + unused_count, sample_count,
                 tick_count, press_count, unused_count, results_checked, LAST_PHASE + 1);
        $display("modes seen: heat %0d tariff %0d sunny %0d forced %0d temp-ok %0d manual %0d idle %0d full %0d",
                 mode_seen[MODE_HEAT], mode_seen[MODE_TARIFF], mode_seen[MODE_SUNNY],
                 mode_seen[MODE_FORCED], mode_seen[MODE_TEMP_OK], mode_seen[MODE_MANUAL],
                 mode_seen[MODE_IDLE], mode_seen[MODE_FULL]);
        if (errors == 0) begin
            $display("tb_solar_surplus_heater_controller OK");
        end else begin
            $display("tb_solar_surplus_heater_controller NOT OK");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/ssh_pkg.sv
hw/rtl/ssh_ring_avg.sv
hw/rtl/ssh_ctrl.sv
hw/rtl/solar_surplus_heater_controller.sv
sim/tb_solar_surplus_heater_controller.sv
